FILE: rtl/nmea_sentence_field_splitter_defines.svh
// Assertion helpers for the NMEA field splitter.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef NMEA_SENTENCE_FIELD_SPLITTER_DEFINES_SVH
`define NMEA_SENTENCE_FIELD_SPLITTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define NSFS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsfs assertion failed");

// Next-cycle implication
`define NSFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsfs assertion failed");

`else

`define NSFS_ASSERT_NOW(lbl, ante, cons)
`define NSFS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/nsfs_pkg.sv
package nsfs_pkg;

    // Sizing of the field counters
    localparam int FIELD_CHARS = 16;
    localparam int MAX_FIELDS  = 32;
    localparam int FIELD_CAP   = (MAX_FIELDS - 1 < 31) ? (MAX_FIELDS - 1) : 31;
    localparam int CHAR_CAP    = (FIELD_CHARS - 1 < 15) ? (FIELD_CHARS - 1) : 15;
    localparam logic [4:0] FIELD_LIMIT = FIELD_CAP[4:0];
    localparam logic [3:0] CHAR_LIMIT  = CHAR_CAP[3:0];

    // Queue sizing shared by the front and back queues
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Sentence kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NONE = 2'd0;
    localparam kind_t KIND_GGA  = 2'd1;
    localparam kind_t KIND_RMC  = 2'd2;
    localparam kind_t KIND_GLL  = 2'd3;

    // Special characters
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Type tags, first character in the top byte
    localparam logic [23:0] TAG_GGA = {8'h47, 8'h47, 8'h41};
    localparam logic [23:0] TAG_RMC = {8'h52, 8'h4D, 8'h43};
    localparam logic [23:0] TAG_GLL = {8'h47, 8'h4C, 8'h4C};

    // Type capture window within the six-byte header
    localparam logic [2:0] TYPE_POS_FIRST = 3'd3;
    localparam logic [2:0] TYPE_POS_MID   = 3'd4;
    localparam logic [2:0] TYPE_POS_LAST  = 3'd5;
    localparam logic [2:0] TYPE_POS_END   = 3'd6;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_GGA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_RMC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_GLL = 2'd2;

    typedef struct packed {
        logic gga;
        logic rmc;
        logic gll;
    } cfg_t;

    // Byte classes decided by the front end
    typedef enum logic [1:0] {
        CLS_OTHER,
        CLS_DOLLAR,
        CLS_SEP,
        CLS_EOL
    } byte_class_t;

    typedef struct packed {
        byte_class_t cls;
        logic [7:0]  data;
    } item_t;

    // Field map codes
    typedef logic [1:0] map_t;
    localparam map_t MAP_NONE = 2'd0;
    localparam map_t MAP_ADV  = 2'd1;
    localparam map_t MAP_HOLD = 2'd2;

    typedef struct packed {
        logic       capture_valid;
        kind_t      sentence_kind;
        logic [4:0] field_number;
        logic [3:0] char_position;
        logic [7:0] data_byte;
        logic       type_detected;
        logic       sentence_done;
    } result_t;

    // Which fields each sentence kind captures, and whether they count chars
    function automatic map_t field_map(input kind_t kind, input logic [4:0] field);
        map_t code;
        code = MAP_NONE;
        unique case (kind)
            KIND_GGA:
            begin
                if (field == 5'd3 || field == 5'd5 || field == 5'd6)
                    code = MAP_HOLD;
                else if ((field >= 5'd1 && field <= 5'd12) || field == 5'd15)
                    code = MAP_ADV;
            end
            KIND_RMC:
            begin
                if ((field >= 5'd1 && field <= 5'd11) || field == 5'd13)
                    code = MAP_ADV;
            end
            KIND_GLL:
            begin
                if (field >= 5'd1 && field <= 5'd8)
                    code = MAP_ADV;
            end
            KIND_NONE:
            begin
                code = MAP_NONE;
            end
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/nsfs_front.sv
module nsfs_front
    import nsfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] rx_byte,
    output logic       full,
    output logic       item_valid,
    output item_t      item,
    input  logic       item_take
);

    item_t              q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    item_t              new_item;
    logic               push_ok;
    logic               take_ok;

    // Classify the incoming byte
    always_comb
    begin
        new_item.data = rx_byte;
        if (rx_byte == CH_DOLLAR)
            new_item.cls = CLS_DOLLAR;
        else if (rx_byte == CH_COMMA || rx_byte == CH_STAR)
            new_item.cls = CLS_SEP;
        else if (rx_byte == CH_NEWLINE)
            new_item.cls = CLS_EOL;
        else
            new_item.cls = CLS_OTHER;
    end

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = q_mem_reg[rd_ptr_reg];
    assign push_ok    = push && !full;
    assign take_ok    = item_take && item_valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (take_ok)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push_ok && !take_ok)
            count_next = count_reg + 1'b1;
        else if (take_ok && !push_ok)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
            q_mem_reg[wr_ptr_reg] <= new_item;
    end

endmodule

FILE: rtl/nsfs_back.sv
module nsfs_back
    import nsfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    input  item_t   item,
    output logic    item_take,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    // Parser state
    logic             type_capturing_reg, type_capturing_next;
    logic [2:0]       type_pos_reg, type_pos_next;
    logic [23:0]      type_chars_reg, type_chars_next;
    kind_t            current_kind_reg, current_kind_next;
    logic [4:0]       field_count_reg, field_count_next;
    logic [3:0]       char_count_reg, char_count_next;

    // Result queue
    result_t          q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_full;
    logic             pop_ok;

    // Decode helpers
    logic             kind_en;
    logic             cap_start;
    logic             cap_act;
    logic [2:0]       pos_cur;
    logic [2:0]       pos_adv;
    logic [23:0]      chars_w;
    kind_t            match_kind;
    map_t             map_code;
    result_t          res;

    assign out_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign item_take = item_valid && !out_full;
    assign pop_ok    = pop && !empty;
    assign result    = q_mem_reg[rd_ptr_reg];

    // Is the current kind still enabled
    always_comb
    begin
        unique case (current_kind_reg)
            KIND_GGA:  kind_en = cfg.gga;
            KIND_RMC:  kind_en = cfg.rmc;
            KIND_GLL:  kind_en = cfg.gll;
            KIND_NONE: kind_en = 1'b0;
        endcase
    end

    // Type capture path
    always_comb
    begin
        cap_start = (item.cls == CLS_DOLLAR);
        cap_act   = cap_start || type_capturing_reg;
        pos_cur   = cap_start ? 3'd0 : type_pos_reg;
        pos_adv   = pos_cur + 3'd1;
        chars_w   = type_chars_reg;
        if (pos_cur == TYPE_POS_FIRST)
            chars_w[23:16] = item.data;
        else if (pos_cur == TYPE_POS_MID)
            chars_w[15:8] = item.data;
        else if (pos_cur == TYPE_POS_LAST)
            chars_w[7:0] = item.data;

        priority if (chars_w == TAG_GLL && cfg.gll)
            match_kind = KIND_GLL;
        else if (chars_w == TAG_RMC && cfg.rmc)
            match_kind = KIND_RMC;
        else if (chars_w == TAG_GGA && cfg.gga)
            match_kind = KIND_GGA;
        else
            match_kind = KIND_NONE;
    end

    assign map_code = field_map(current_kind_reg, field_count_reg);

    // Per-beat state update and result
    always_comb
    begin
        type_capturing_next = type_capturing_reg;
        type_pos_next       = type_pos_reg;
        type_chars_next     = type_chars_reg;
        current_kind_next   = current_kind_reg;
        field_count_next    = field_count_reg;
        char_count_next     = char_count_reg;
        res                 = '0;

        if (item_take)
        begin
            if (current_kind_reg == KIND_NONE)
            begin
                // hunting for a sentence header
                if (cap_act)
                begin
                    type_capturing_next = 1'b1;
                    type_pos_next       = pos_adv;
                    type_chars_next     = chars_w;
                    if (pos_adv >= TYPE_POS_END)
                    begin
                        type_capturing_next = 1'b0;
                        current_kind_next   = match_kind;
                        if (match_kind != KIND_NONE)
                        begin
                            res.type_detected = 1'b1;
                            res.sentence_kind = match_kind;
                        end
                    end
                end
            end
            else if (kind_en)
            begin
                unique case (item.cls)
                    CLS_SEP:
                    begin
                        char_count_next = '0;
                        if (field_count_reg < FIELD_LIMIT)
                            field_count_next = field_count_reg + 5'd1;
                    end
                    CLS_EOL:
                    begin
                        res.sentence_done   = 1'b1;
                        res.sentence_kind   = current_kind_reg;
                        char_count_next     = '0;
                        field_count_next    = '0;
                        current_kind_next   = KIND_NONE;
                        type_capturing_next = 1'b1;
                        type_pos_next       = '0;
                    end
                    CLS_OTHER, CLS_DOLLAR:
                    begin
                        if (map_code != MAP_NONE)
                        begin
                            res.capture_valid = 1'b1;
                            res.sentence_kind = current_kind_reg;
                            res.field_number  = field_count_reg;
                            res.char_position = char_count_reg;
                            res.data_byte     = item.data;
                            if (map_code == MAP_ADV && char_count_reg < CHAR_LIMIT)
                                char_count_next = char_count_reg + 4'd1;
                        end
                    end
                endcase
            end
        end
    end

    // Result queue bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (item_take)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop_ok)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (item_take && !pop_ok)
            count_next = count_reg + 1'b1;
        else if (pop_ok && !item_take)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_capturing_reg <= 1'b0;
            type_pos_reg       <= '0;
            type_chars_reg     <= '0;
            current_kind_reg   <= KIND_NONE;
            field_count_reg    <= '0;
            char_count_reg     <= '0;
            wr_ptr_reg         <= '0;
            rd_ptr_reg         <= '0;
            count_reg          <= '0;
        end
        else
        begin
            type_capturing_reg <= type_capturing_next;
            type_pos_reg       <= type_pos_next;
            type_chars_reg     <= type_chars_next;
            current_kind_reg   <= current_kind_next;
            field_count_reg    <= field_count_next;
            char_count_reg     <= char_count_next;
            wr_ptr_reg         <= wr_ptr_next;
            rd_ptr_reg         <= rd_ptr_next;
            count_reg          <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (item_take)
            q_mem_reg[wr_ptr_reg] <= res;
    end

endmodule

FILE: rtl/nmea_sentence_field_splitter.sv
// NMEA 0183 sentence field splitter. Push one received byte per beat; every
// byte yields exactly one result beat on the output queue, in order. A '$'
// header selects GGA, RMC or GLL (if enabled through cfg_we/cfg_index/
// cfg_data: index 0 GGA, 1 RMC, 2 GLL), after which ',' and '*' step the
// field number and newline ends the sentence with sentence_done. Bytes of
// fields the sentence kind captures come out with capture_valid, kind, field
// number and character position; other beats carry zero field number,
// character position and data byte. A byte is taken every clock while full
// is low, so one byte per cycle is sustained; full only rises when the
// result side stops popping and both two-entry queues back up. An accepted
// byte is stored in the classify queue; the combinational decode then writes
// its result into the result queue once that queue has room, and the result
// waits at the output until popped.
// Change the enables only while no byte is in flight.
`include "nmea_sentence_field_splitter_defines.svh"

module nmea_sentence_field_splitter
    import nsfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [7:0]           rx_byte,
    output logic                 full,
    output logic                 empty,
    input  logic                 pop,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    output logic                 capture_valid,
    output logic [1:0]           sentence_kind,
    output logic [4:0]           field_number,
    output logic [3:0]           char_position,
    output logic [7:0]           data_byte,
    output logic                 type_detected,
    output logic                 sentence_done
);

    cfg_t    cfg_reg, cfg_next;
    logic    fq_valid;
    item_t   fq_item;
    logic    fq_take;
    result_t bq_result;

    // Enable registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE_GGA: cfg_next.gga = cfg_data;
                CFG_ENABLE_RMC: cfg_next.rmc = cfg_data;
                CFG_ENABLE_GLL: cfg_next.gll = cfg_data;
                default:        cfg_next     = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gga <= 1'b0;
            cfg_reg.rmc <= 1'b1;
            cfg_reg.gll <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Byte classification and queue
    nsfs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .rx_byte    (rx_byte),
        .full       (full),
        .item_valid (fq_valid),
        .item       (fq_item),
        .item_take  (fq_take)
    );

    // Sentence decode and result queue
    nsfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (fq_valid),
        .item       (fq_item),
        .item_take  (fq_take),
        .empty      (empty),
        .pop        (pop),
        .result     (bq_result)
    );

    assign capture_valid = bq_result.capture_valid;
    assign sentence_kind = bq_result.sentence_kind;
    assign field_number  = bq_result.field_number;
    assign char_position = bq_result.char_position;
    assign data_byte     = bq_result.data_byte;
    assign type_detected = bq_result.type_detected;
    assign sentence_done = bq_result.sentence_done;

    // Checks
    `NSFS_ASSERT_NEXT(a_no_result_from_nothing, empty && !fq_valid, empty)
    `NSFS_ASSERT_NOW(a_full_has_item, full, fq_valid)
    `NSFS_ASSERT_NOW(a_capture_has_kind, !empty && capture_valid, sentence_kind != KIND_NONE)
    `NSFS_ASSERT_NOW(a_idle_fields_zero, !empty && !capture_valid, field_number == 5'd0 && char_position == 4'd0 && data_byte == 8'd0)

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb
    import nsfs_pkg::*;
();

    // Unused register index; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic [7:0]           rx_byte = 8'h00;
    logic                 full;
    logic                 empty;
    logic                 pop = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_data = 1'b0;
    logic                 capture_valid;
    logic [1:0]           sentence_kind;
    logic [4:0]           field_number;
    logic [3:0]           char_position;
    logic [7:0]           data_byte;
    logic                 type_detected;
    logic                 sentence_done;

    nmea_sentence_field_splitter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .rx_byte       (rx_byte),
        .full          (full),
        .empty         (empty),
        .pop           (pop),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .capture_valid (capture_valid),
        .sentence_kind (sentence_kind),
        .field_number  (field_number),
        .char_position (char_position),
        .data_byte     (data_byte),
        .type_detected (type_detected),
        .sentence_done (sentence_done)
    );

    always #5 clk = ~clk;

    // Bytes waiting to be pushed, and split results waiting to pop out
    logic [7:0] tx_bytes[$];
    result_t    split_results[$];
    int         bad_beats = 0;

    // Shadow of the splitter state and enables
    cfg_t       en;
    logic       hunt_on;
    logic [2:0] hunt_pos;
    logic [7:0] tag [3];
    kind_t      cur_kind;
    logic [4:0] fld_cnt;
    logic [3:0] chr_cnt;

    function automatic logic kind_on(input kind_t k);
        case (k)
            KIND_GGA: return en.gga;
            KIND_RMC: return en.rmc;
            KIND_GLL: return en.gll;
            default:  return 1'b0;
        endcase
    endfunction

    // Which fields a sentence kind keeps, and whether chars step the position
    function automatic map_t capture_mode(input kind_t k, input logic [4:0] f);
        case (k)
            KIND_GGA:
            begin
                if (f == 5'd3 || f == 5'd5 || f == 5'd6)
                    return MAP_HOLD;
                if ((f != 5'd0 && f < 5'd13) || f == 5'd15)
                    return MAP_ADV;
            end
            KIND_RMC:
            begin
                if ((f != 5'd0 && f < 5'd12) || f == 5'd13)
                    return MAP_ADV;
            end
            KIND_GLL:
            begin
                if (f != 5'd0 && f < 5'd9)
                    return MAP_ADV;
            end
            default: ;
        endcase
        return MAP_NONE;
    endfunction

    // Advance the shadow state by one byte and return the beat it yields
    function automatic result_t split_byte(input logic [7:0] b);
        result_t r;
        map_t    m;
        r = '0;
        if (cur_kind == KIND_NONE)
        begin
            if (b == CH_DOLLAR)
            begin
                hunt_on = 1'b1;
                hunt_pos = 3'd0;
            end
            if (hunt_on)
            begin
                if (hunt_pos >= TYPE_POS_FIRST && hunt_pos <= TYPE_POS_LAST)
                    tag[2'(hunt_pos - TYPE_POS_FIRST)] = b;
                hunt_pos = hunt_pos + 3'd1;
                if (hunt_pos >= TYPE_POS_END)
                begin
                    hunt_on = 1'b0;
                    if ({tag[0], tag[1], tag[2]} == TAG_GGA && en.gga)
                        cur_kind = KIND_GGA;
                    if ({tag[0], tag[1], tag[2]} == TAG_RMC && en.rmc)
                        cur_kind = KIND_RMC;
                    if ({tag[0], tag[1], tag[2]} == TAG_GLL && en.gll)
                        cur_kind = KIND_GLL;
                    if (cur_kind != KIND_NONE)
                    begin
                        r.type_detected = 1'b1;
                        r.sentence_kind = cur_kind;
                    end
                end
            end
        end
        else if (kind_on(cur_kind))
        begin
            if (b == CH_COMMA || b == CH_STAR)
            begin
                chr_cnt = 4'd0;
                if (fld_cnt < FIELD_LIMIT)
                    fld_cnt = fld_cnt + 5'd1;
            end
            else if (b == CH_NEWLINE)
            begin
                r.sentence_done = 1'b1;
                r.sentence_kind = cur_kind;
                chr_cnt = 4'd0;
                fld_cnt = 5'd0;
                cur_kind = KIND_NONE;
                hunt_on = 1'b1;
                hunt_pos = 3'd0;
            end
            else
            begin
                m = capture_mode(cur_kind, fld_cnt);
                if (m != MAP_NONE)
                begin
                    r.capture_valid = 1'b1;
                    r.sentence_kind = cur_kind;
                    r.field_number = fld_cnt;
                    r.char_position = chr_cnt;
                    r.data_byte = b;
                    if (m == MAP_ADV && chr_cnt < CHAR_LIMIT)
                        chr_cnt = chr_cnt + 4'd1;
                end
            end
        end
        return r;
    endfunction

    // Driver: bursts of random length with random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            rx_byte <= 8'h00;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!(push && full))
        begin
            // beat taken at this edge
            if (push)
            begin
                split_results.push_back(split_byte(rx_byte));
                void'(tx_bytes.pop_front());
                if (burst_left > 0)
                    burst_left--;
            end
            if (burst_left == 0 && gap_left == 0)
            begin
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 40);
            end
            if (gap_left > 0)
            begin
                push <= 1'b0;
                gap_left--;
            end
            else if (tx_bytes.size() > 0)
            begin
                push <= 1'b1;
                rx_byte <= tx_bytes[0];
            end
            else
                push <= 1'b0;
        end
    end

    // Monitor: checks each popped beat, stalls on a rotating pattern
    int      beats_seen;
    int      hold_left;
    int      pace_cnt;
    result_t got;
    result_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            beats_seen = 0;
            hold_left = 0;
            pace_cnt = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got = {capture_valid, sentence_kind, field_number, char_position,
                       data_byte, type_detected, sentence_done};
                if (split_results.size() == 0)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("mismatch: beat with nothing pending, got %h", got);
                end
                else
                begin
                    want = split_results.pop_front();
                    if (got !== want)
                    begin
                        bad_beats++;
                        if (bad_beats <= 10)
                            $display({"mismatch at beat %0d: exp v%b k%0d f%0d c%0d d%h t%b s%b",
                                      " / got v%b k%0d f%0d c%0d d%h t%b s%b"},
                                     beats_seen,
                                     want.capture_valid, want.sentence_kind,
                                     want.field_number, want.char_position,
                                     want.data_byte, want.type_detected,
                                     want.sentence_done,
                                     got.capture_valid, got.sentence_kind,
                                     got.field_number, got.char_position,
                                     got.data_byte, got.type_detected,
                                     got.sentence_done);
                    end
                end
                beats_seen++;
                // long hold-off so the input side backs up
                if (beats_seen == 300 || beats_seen == 900)
                    hold_left = 160;
            end
            pace_cnt++;
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
            begin
                case (pace_cnt[7:6])
                    2'd0: pop <= 1'b1;
                    2'd1: pop <= pace_cnt[0];
                    2'd2: pop <= ($urandom_range(0, 9) < 7);
                    default: pop <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // Register write; block is idle whenever this is called
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE_GGA: en.gga = val;
            CFG_ENABLE_RMC: en.rmc = val;
            CFG_ENABLE_GLL: en.gll = val;
            default: ;
        endcase
    endtask

    task automatic write_enables(input logic gga, input logic rmc, input logic gll);
        write_reg(CFG_ENABLE_GGA, gga);
        write_reg(CFG_ENABLE_RMC, rmc);
        write_reg(CFG_ENABLE_GLL, gll);
    endtask

    // Wait until every pushed byte has popped out, then a few more cycles
    task automatic settle();
        while (tx_bytes.size() != 0 || split_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            tx_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] upper_char();
        return 8'h41 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] field_char();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'($urandom_range(0, 255));
        if (r < 3)
            return 8'h2E;
        if (r < 6)
            return upper_char();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    // One sentence, mostly well formed, sometimes broken or plain noise
    task automatic queue_sentence();
        string tags[3];
        int    r;
        int    nf;
        int    len;
        tags = '{"GGA", "RMC", "GLL"};
        r = $urandom_range(0, 9);
        if (r < 8)
        begin
            tx_bytes.push_back(CH_DOLLAR);
            if ($urandom_range(0, 3) != 0)
                send_text("GP");
            else
            begin
                tx_bytes.push_back(upper_char());
                tx_bytes.push_back(upper_char());
            end
            send_text(tags[$urandom_range(0, 2)]);
        end
        else if (r == 8)
        begin
            tx_bytes.push_back(CH_DOLLAR);
            repeat (5) tx_bytes.push_back(upper_char());
        end
        else
        begin
            repeat ($urandom_range(1, 8)) tx_bytes.push_back(8'($urandom_range(0, 255)));
        end
        nf = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
        for (int f = 0; f < nf; f++)
        begin
            tx_bytes.push_back(($urandom_range(0, 4) == 0) ? CH_STAR : CH_COMMA);
            len = ($urandom_range(0, 14) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 6);
            repeat (len) tx_bytes.push_back(field_char());
        end
        if ($urandom_range(0, 11) != 0)
            tx_bytes.push_back(CH_NEWLINE);
    endtask

    logic [2:0] mixes [5];

    initial
    begin
        en = '{gga: 1'b0, rmc: 1'b1, gll: 1'b0};
        hunt_on = 1'b0;
        hunt_pos = 3'd0;
        tag = '{8'h00, 8'h00, 8'h00};
        cur_kind = KIND_NONE;
        fld_cnt = 5'd0;
        chr_cnt = 4'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset enables: GGA ignored, RMC found, extreme bytes in a field,
        // then a header taken right after newline without a dollar sign
        send_text("$GPGGA$GPRMC,");
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(8'h00);
        send_text("*\nzzzRMC\n");
        settle();

        // GGA hold fields; an unused index write must not disturb anything
        write_enables(1'b1, 1'b0, 1'b1);
        write_reg(CFG_UNUSED, 1'b1);
        send_text("$GPGGA,,,ab,,c,d");
        settle();

        // GGA switched off mid-sentence: everything ignored, newline too
        write_reg(CFG_ENABLE_GGA, 1'b0);
        send_text("e\n");
        settle();
        write_reg(CFG_ENABLE_GGA, 1'b1);
        send_text("\n");
        settle();

        // Random phases over a spread of enable settings (gga, rmc, gll)
        mixes = '{3'b111, 3'b000, 3'b101, 3'b010, 3'b111};
        for (int p = 0; p < 7; p++)
        begin
            if (p < 5)
                write_enables(mixes[p][2], mixes[p][1], mixes[p][0]);
            else
                write_enables(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            if (p == 3)
                write_reg(CFG_UNUSED, 1'b0);
            while (tx_bytes.size() < 200)
                queue_sentence();
            settle();
        end

        if (bad_beats == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
